// File: rtl/core/sdhc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Heat colormap package
// Widths, constants, the log2 fraction table and the divider step used by the
// spectrum dB heat colormap pipeline.
// ----------------------------------------------------------------------------
package sdhc_pkg;

    // Magnitude input, unsigned Q8.24.
    localparam int MAG_W         = 32;
    localparam int MAG_FRAC_BITS = 24;
    localparam int POS_W         = $clog2(MAG_W);

    // Log2 fraction table.
    localparam int LOG_TABLE_BITS = 6;
    localparam int LOG_TABLE_SIZE = 1 << LOG_TABLE_BITS;
    localparam int LOG_FRAC_W     = 17;
    localparam int LOG_ITER       = 20;

    // log2 in Q.16: the exponent part covers -24..7.
    localparam int EXP_W = POS_W + 1;
    localparam int LOG_W = EXP_W + 16;

    // 20*log10(2) in Q.16, then rescale by 2^24 down to Q8.8 dB.
    localparam int DB_K_W   = 20;
    localparam int PROD_W   = LOG_W + DB_K_W;
    localparam int DB_SHIFT = 24;
    localparam int DBW_W    = PROD_W - DB_SHIFT;
    localparam int DB_W     = 16;
    localparam logic signed [DB_K_W-1:0] DB_K_Q16 = 20'sd394566;
    localparam logic signed [DB_W-1:0]   DB_MIN   = 16'sh8000;
    localparam logic signed [DB_W-1:0]   DB_MAX   = 16'sh7FFF;

    // Configuration registers.
    localparam int CFG_ADDR_W = 1;
    localparam logic [CFG_ADDR_W-1:0] REG_DB_FLOOR   = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_DB_CEILING = 1'b1;
    localparam logic signed [DB_W-1:0] DB_FLOOR_RESET   = -16'sd28160;
    localparam logic signed [DB_W-1:0] DB_CEILING_RESET = -16'sd2560;

    // Normalized level, Q0.16.
    localparam int LVL_W = 16;
    localparam int DIFF_W = DB_W + 1;
    localparam logic [LVL_W-1:0] LVL_ONE  = 16'd65535;
    localparam logic [LVL_W-1:0] LVL_SEG1 = 16'd39321;
    localparam logic [LVL_W-1:0] LVL_SEG2 = 16'd55705;
    localparam logic [LVL_W-1:0] MID_SPAN  = LVL_SEG2 - LVL_SEG1;
    localparam logic [LVL_W-1:0] HIGH_SPAN = LVL_ONE - LVL_SEG2;

    // Level divider: quotient of (2*num*65535 + den) / (2*den).
    localparam int QUO_W              = LVL_W;
    localparam int REM_W              = DIFF_W;
    localparam int DIVIDEND_W         = QUO_W + REM_W;
    localparam int DIV_BITS_PER_STAGE = 2;
    localparam int DIV_STAGES         = QUO_W / DIV_BITS_PER_STAGE;

    // Color arithmetic.
    localparam int CH_W        = 8;
    localparam int X_W         = 24;
    localparam int RECIP_SHIFT = X_W;
    localparam int RECIP_W     = 10;
    localparam int QC_W        = X_W + 1;
    localparam int C_W         = 17;
    localparam logic [X_W-1:0]  SEG1_GAIN  = X_W'(2 * 195);
    localparam logic [X_W-1:0]  COLOR_GAIN = X_W'(2 * 255);
    localparam logic [C_W-1:0]  C_SEG1     = C_W'(2 * int'(LVL_SEG1));
    localparam logic [C_W-1:0]  C_SEG3     = C_W'(2 * int'(HIGH_SPAN));
    localparam logic [RECIP_W-1:0] M_SEG1  = RECIP_W'((64'd1 << RECIP_SHIFT) / C_SEG1);
    localparam logic [RECIP_W-1:0] M_SEG3  = RECIP_W'((64'd1 << RECIP_SHIFT) / C_SEG3);
    localparam int MID_SHIFT = $clog2(2 * int'(MID_SPAN));
    localparam logic [CH_W-1:0] LOW_BASE = 8'd60;
    localparam logic [CH_W-1:0] CH_FULL  = 8'hFF;

    // Pipeline stage map.
    localparam int ST_LOD     = 0;
    localparam int ST_LOG     = 1;
    localparam int ST_MUL     = 2;
    localparam int ST_DB      = 3;
    localparam int ST_DIFF    = 4;
    localparam int ST_DIVIN   = 5;
    localparam int ST_DIV0    = 6;
    localparam int ST_SEG     = ST_DIV0 + DIV_STAGES;
    localparam int ST_RECIP   = ST_SEG + 1;
    localparam int ST_OUT     = ST_RECIP + 1;
    localparam int NUM_STAGES = ST_OUT + 1;

    localparam int OUT_DATA_W = 3 * CH_W + LVL_W;

    typedef enum logic [1:0] {
        SEG_LOW,
        SEG_MID,
        SEG_HIGH
    } seg_t;

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [QUO_W-1:0] lo;
        logic [QUO_W-1:0] quo;
        logic [REM_W-1:0] dvs;
        logic             zero;
        logic             one;
    } div_t;

    typedef logic [LOG_FRAC_W-1:0] log_rom_t [LOG_TABLE_SIZE];

    // Fraction of log2(1 + idx/2^B) in Q.16, by repeated squaring.
    function automatic log_rom_t build_log_rom();
        log_rom_t    rom;
        logic [63:0] y;
        logic [LOG_ITER:0] r;
        int          i;
        int          k;
        for (i = 0; i < LOG_TABLE_SIZE; i++) begin
            y = 64'(LOG_TABLE_SIZE + i) << (30 - LOG_TABLE_BITS);
            r = '0;
            for (k = 0; k < LOG_ITER; k++) begin
                y = (y * y) >> 30;
                r = r << 1;
                if (y >= (64'd1 << 31)) begin
                    r[0] = 1'b1;
                    y = y >> 1;
                end
            end
            rom[i] = LOG_FRAC_W'((r + (LOG_ITER + 1)'(8)) >> 4);
        end
        return rom;
    endfunction

    localparam log_rom_t LOG_ROM = build_log_rom();

    // One restoring step: brings in the next dividend bit.
    function automatic div_t div_step(input div_t s);
        div_t             o;
        logic [REM_W:0]   t;
        o = s;
        t = {s.rem, s.lo[QUO_W-1]};
        if (t >= {1'b0, s.dvs}) begin
            o.rem = REM_W'(t - {1'b0, s.dvs});
            o.quo = {s.quo[QUO_W-2:0], 1'b1};
        end else begin
            o.rem = t[REM_W-1:0];
            o.quo = {s.quo[QUO_W-2:0], 1'b0};
        end
        o.lo = {s.lo[QUO_W-2:0], 1'b0};
        return o;
    endfunction

    function automatic div_t div_stage(input div_t s);
        div_t o;
        int   b;
        o = s;
        for (b = 0; b < DIV_BITS_PER_STAGE; b++) begin
            o = div_step(o);
        end
        return o;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/spectrum_db_heat_colormap.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Spectrum dB heat colormap
// Turns one linear spectrum bin magnitude into a dB level and a heat color.
//
// Input stream: s_axis carries one unsigned Q8.24 magnitude per item. Output
// stream: m_axis carries the rounded red, green, blue components and the
// clamped Q0.16 level of that bin, in input order, one result per item.
// The floor and ceiling (signed Q8.8 dB) are written on the cfg port; the user
// must write them only while the block is idle, which the block does not enforce.
// The pipeline has 17 register stages and takes one item every cycle unless
// m_axis stalls while every stage holds an item. The level divider is eight
// stages of two quotient bits each, which sets the depth. Reset empties the
// pipeline and loads the floor and ceiling with -110 dB and -10 dB. When the
// receiver stalls, the items behind the output register close up any empty
// stages, and s_axis_tready drops only once every stage holds an item.
// ----------------------------------------------------------------------------
module spectrum_db_heat_colormap (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // [31:0] magnitude
    input  logic [sdhc_pkg::MAG_W-1:0]             s_axis_tdata,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // [7:0] red, [15:8] green, [23:16] blue, [39:24] level
    output logic [sdhc_pkg::OUT_DATA_W-1:0]        m_axis_tdata,
    input  logic                                   cfg_wr_en,
    input  logic [sdhc_pkg::CFG_ADDR_W-1:0]        cfg_addr,
    input  logic [sdhc_pkg::DB_W-1:0]              cfg_wdata
);
    import sdhc_pkg::*;

    logic signed [DB_W-1:0] floor_reg;
    logic signed [DB_W-1:0] ceil_reg;

    logic [NUM_STAGES-1:0] vld_reg;
    logic [NUM_STAGES-1:0] vld_next;
    logic [NUM_STAGES-1:0] stage_en;

    // Stage registers.
    logic [MAG_W-1:0]          mag0_reg;
    logic [POS_W-1:0]          pos0_reg;
    logic signed [LOG_W-1:0]   log1_reg;
    logic signed [PROD_W-1:0]  prod2_reg;
    logic signed [DB_W-1:0]    db3_reg;
    logic signed [DIFF_W-1:0]  num4_reg;
    logic signed [DIFF_W-1:0]  den4_reg;
    div_t                      div_pipe_reg [DIV_STAGES+1];
    logic [LVL_W-1:0]          level14_reg;
    seg_t                      seg14_reg;
    logic [X_W-1:0]            x14_reg;
    logic [CH_W-1:0]           rmid14_reg;
    logic [CH_W-1:0]           bmid14_reg;
    logic [LVL_W-1:0]          level15_reg;
    seg_t                      seg15_reg;
    logic [X_W-1:0]            x15_reg;
    logic [CH_W-1:0]           rmid15_reg;
    logic [CH_W-1:0]           bmid15_reg;
    logic [CH_W-1:0]           qe15_reg;
    logic [CH_W-1:0]           out_red_reg;
    logic [CH_W-1:0]           out_green_reg;
    logic [CH_W-1:0]           out_blue_reg;
    logic [LVL_W-1:0]          out_level_reg;

    // Combinational values.
    logic [MAG_W-1:0]          mag_c;
    logic [POS_W-1:0]          pos_c;
    logic [MAG_W-1:0]          norm_c;
    logic [LOG_TABLE_BITS-1:0] idx_c;
    logic signed [EXP_W-1:0]   exp_c;
    logic signed [LOG_W-1:0]   log_c;
    logic signed [PROD_W-1:0]  prod_c;
    logic signed [PROD_W-1:0]  db_sum_c;
    logic signed [DBW_W-1:0]   db_wide_c;
    logic signed [DB_W-1:0]    db_c;
    logic [DIVIDEND_W-1:0]     dividend_c;
    div_t                      div_init_c;
    div_t                      div_last_c;
    logic [LVL_W-1:0]          level_c;
    logic [LVL_W-1:0]          dmid_c;
    logic [LVL_W-1:0]          dhigh_c;
    seg_t                      seg_c;
    logic [X_W-1:0]            x_c;
    logic [X_W-1:0]            rmid_t_c;
    logic [X_W-1:0]            bmid_t_c;
    logic [RECIP_W-1:0]        recip_c;
    logic [X_W+RECIP_W-1:0]    qprod_c;
    logic [C_W-1:0]            cdiv_c;
    logic [QC_W-1:0]           rem_c;
    logic [CH_W-1:0]           q_c;
    logic [CH_W-1:0]           red_next;
    logic [CH_W-1:0]           green_next;
    logic [CH_W-1:0]           blue_next;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            floor_reg <= DB_FLOOR_RESET;
            ceil_reg  <= DB_CEILING_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_DB_FLOOR:   floor_reg <= cfg_wdata;
                REG_DB_CEILING: ceil_reg  <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline flow control: a stage loads when it is empty or when some
    // stage at or after it is empty or the output is being taken.
    // ------------------------------------------------------------------
    always_comb begin
        for (int k = 0; k < NUM_STAGES; k++) begin
            stage_en[k] = m_axis_tready ||
                          ((vld_reg | NUM_STAGES'((1 << k) - 1)) != '1);
        end
    end

    assign vld_next      = {vld_reg[NUM_STAGES-2:0], s_axis_tvalid};
    assign s_axis_tready = stage_en[ST_LOD];
    assign m_axis_tvalid = vld_reg[ST_OUT];
    assign m_axis_tdata  = {out_level_reg, out_blue_reg, out_green_reg, out_red_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            for (int k = 0; k < NUM_STAGES; k++) begin
                if (stage_en[k]) begin
                    vld_reg[k] <= vld_next[k];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Leading-one position (zero counts as one LSB)
    // ------------------------------------------------------------------
    always_comb begin
        mag_c = (s_axis_tdata == '0) ? MAG_W'(1) : s_axis_tdata;
        pos_c = '0;
        for (int i = 0; i < MAG_W; i++) begin
            if (mag_c[i]) begin
                pos_c = POS_W'(i);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[ST_LOD]) begin
            mag0_reg <= mag_c;
            pos0_reg <= pos_c;
        end
    end

    // ------------------------------------------------------------------
    // log2 in Q.16: exponent plus table fraction
    // ------------------------------------------------------------------
    always_comb begin
        norm_c = mag0_reg << (POS_W'(MAG_W - 1) - pos0_reg);
        idx_c  = norm_c[MAG_W-2 -: LOG_TABLE_BITS];
        exp_c  = $signed({1'b0, pos0_reg}) - $signed(EXP_W'(MAG_FRAC_BITS));
        log_c  = $signed({exp_c, 16'b0})
               + $signed({{(LOG_W - LOG_FRAC_W){1'b0}}, LOG_ROM[idx_c]});
    end

    always_ff @(posedge aclk) begin
        if (stage_en[ST_LOG]) begin
            log1_reg <= log_c;
        end
    end

    assign prod_c = log1_reg * DB_K_Q16;

    always_ff @(posedge aclk) begin
        if (stage_en[ST_MUL]) begin
            prod2_reg <= prod_c;
        end
    end

    // ------------------------------------------------------------------
    // Round to Q8.8 dB and saturate the low end
    // ------------------------------------------------------------------
    always_comb begin
        db_sum_c  = prod2_reg + $signed(PROD_W'(64'd1 << (DB_SHIFT - 1)));
        db_wide_c = db_sum_c[PROD_W-1:DB_SHIFT];
        if (db_wide_c[DBW_W-1:DB_W-1] != {(DBW_W - DB_W + 1){db_wide_c[DB_W-1]}}) begin
            db_c = db_wide_c[DBW_W-1] ? DB_MIN : DB_MAX;
        end else begin
            db_c = db_wide_c[DB_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[ST_DB]) begin
            db3_reg <= db_c;
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[ST_DIFF]) begin
            num4_reg <= {db3_reg[DB_W-1], db3_reg} - {floor_reg[DB_W-1], floor_reg};
            den4_reg <= {ceil_reg[DB_W-1], ceil_reg} - {floor_reg[DB_W-1], floor_reg};
        end
    end

    // ------------------------------------------------------------------
    // Divider setup. The quotient is only used when 0 < num < den, where
    // it is known to fit in 16 bits.
    // ------------------------------------------------------------------
    always_comb begin
        dividend_c = {num4_reg[QUO_W-1:0], {REM_W{1'b0}}}
                   - {{(REM_W - 1){1'b0}}, num4_reg[QUO_W-1:0], 1'b0}
                   + {{REM_W{1'b0}}, den4_reg[QUO_W-1:0]};
        div_init_c.rem  = dividend_c[DIVIDEND_W-1:QUO_W];
        div_init_c.lo   = dividend_c[QUO_W-1:0];
        div_init_c.quo  = '0;
        div_init_c.dvs  = {den4_reg[QUO_W-1:0], 1'b0};
        div_init_c.zero = (den4_reg <= 17'sd0) || (num4_reg <= 17'sd0);
        div_init_c.one  = (num4_reg >= den4_reg);
    end

    always_ff @(posedge aclk) begin
        if (stage_en[ST_DIVIN]) begin
            div_pipe_reg[0] <= div_init_c;
        end
    end

    for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
        always_ff @(posedge aclk) begin
            if (stage_en[ST_DIV0 + j]) begin
                div_pipe_reg[j+1] <= div_stage(div_pipe_reg[j]);
            end
        end
    end

    // ------------------------------------------------------------------
    // Level and heat segment selection
    // ------------------------------------------------------------------
    always_comb begin
        div_last_c = div_pipe_reg[DIV_STAGES];
        if (div_last_c.zero) begin
            level_c = '0;
        end else if (div_last_c.one) begin
            level_c = LVL_ONE;
        end else begin
            level_c = div_last_c.quo;
        end
        dmid_c   = level_c - LVL_SEG1;
        dhigh_c  = level_c - LVL_SEG2;
        rmid_t_c = X_W'(dmid_c) * COLOR_GAIN + X_W'(MID_SPAN);
        bmid_t_c = X_W'(MID_SPAN - dmid_c) * COLOR_GAIN + X_W'(MID_SPAN);
        if (level_c < LVL_SEG1) begin
            seg_c = SEG_LOW;
            x_c   = X_W'(level_c) * SEG1_GAIN + X_W'(LVL_SEG1);
        end else if (level_c < LVL_SEG2) begin
            seg_c = SEG_MID;
            x_c   = '0;
        end else begin
            seg_c = SEG_HIGH;
            x_c   = X_W'(HIGH_SPAN - dhigh_c) * COLOR_GAIN + X_W'(HIGH_SPAN);
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[ST_SEG]) begin
            level14_reg <= level_c;
            seg14_reg   <= seg_c;
            x14_reg     <= x_c;
            rmid14_reg  <= CH_W'(rmid_t_c >> MID_SHIFT);
            bmid14_reg  <= CH_W'(bmid_t_c >> MID_SHIFT);
        end
    end

    // Reciprocal estimate of the rounded quotient; low by at most one.
    always_comb begin
        recip_c = (seg14_reg == SEG_LOW) ? M_SEG1 : M_SEG3;
        qprod_c = (X_W + RECIP_W)'(x14_reg) * (X_W + RECIP_W)'(recip_c);
    end

    always_ff @(posedge aclk) begin
        if (stage_en[ST_RECIP]) begin
            level15_reg <= level14_reg;
            seg15_reg   <= seg14_reg;
            x15_reg     <= x14_reg;
            rmid15_reg  <= rmid14_reg;
            bmid15_reg  <= bmid14_reg;
            qe15_reg    <= CH_W'(qprod_c >> RECIP_SHIFT);
        end
    end

    // ------------------------------------------------------------------
    // Quotient correction and color assembly
    // ------------------------------------------------------------------
    always_comb begin
        cdiv_c = (seg15_reg == SEG_LOW) ? C_SEG1 : C_SEG3;
        rem_c  = {1'b0, x15_reg} - QC_W'(qe15_reg) * QC_W'(cdiv_c);
        q_c    = qe15_reg + CH_W'(rem_c >= QC_W'(cdiv_c));
        case (seg15_reg)
            SEG_LOW: begin
                red_next   = '0;
                green_next = LOW_BASE + q_c;
                blue_next  = LOW_BASE + q_c;
            end
            SEG_MID: begin
                red_next   = rmid15_reg;
                green_next = CH_FULL;
                blue_next  = bmid15_reg;
            end
            SEG_HIGH: begin
                red_next   = CH_FULL;
                green_next = q_c;
                blue_next  = '0;
            end
            default: begin
                red_next   = '0;
                green_next = '0;
                blue_next  = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (stage_en[ST_OUT]) begin
            out_red_reg   <= red_next;
            out_green_reg <= green_next;
            out_blue_reg  <= blue_next;
            out_level_reg <= level15_reg;
        end
    end

`ifndef NO_ASSERTIONS
    // Low segment is a gray-free teal ramp: no red, green equals blue.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && (out_level_reg < LVL_SEG1)
        |-> (out_red_reg == '0) && (out_green_reg == out_blue_reg))
        else $error("low segment color mismatch");

    // Top segment is full red with no blue.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && (out_level_reg >= LVL_SEG2)
        |-> (out_red_reg == CH_FULL) && (out_blue_reg == '0))
        else $error("high segment color mismatch");

    // A taken output always frees room for a new item.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tready |-> s_axis_tready)
        else $error("input stalled while output drains");

    assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("output valid right after reset");
`endif

endmodule

`default_nettype wire
